/* design/pva_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice allocator package
// Commands, result actions, playback modes and the record types of the
// allocator control; the voice entry type is also used by its voice memory.
// ----------------------------------------------------------------------------
package pva_pkg;

   localparam int DEFAULT_VOICE_COUNT = 8;

   // At most this many results are reported for one input beat.
   localparam int MAX_RESULTS = 9;
   localparam int CNT_W       = 4;

   typedef enum logic [1:0] {
      CMD_NOTE_ON  = 2'd0,
      CMD_NOTE_OFF = 2'd1,
      CMD_STOP     = 2'd2,
      CMD_MUTE     = 2'd3
   } cmd_type;

   localparam logic [2:0] ACT_START    = 3'd0;
   localparam logic [2:0] ACT_STOP     = 3'd1;
   localparam logic [2:0] ACT_END_LOOP = 3'd2;
   localparam logic [2:0] ACT_RELEASE  = 3'd3;
   localparam logic [2:0] ACT_NONE     = 3'd4;

   localparam logic [1:0] MODE_RELEASE = 2'd1;
   localparam logic [1:0] MODE_ONESHOT = 2'd2;

   localparam logic signed [7:0] AGE_FLOOR = -8'sd128;

   // One voice entry. Only meaningful while the voice is playing.
   typedef struct packed {
      logic              loop_on;
      logic [6:0]        key;
      logic signed [7:0] age;
   } voice_word_type;

   typedef struct packed {
      logic [2:0] voice;
      logic [2:0] action;
      logic       looping;
      logic [6:0] key;
      logic [6:0] velocity;
      logic [3:0] highest;
   } result_type;

endpackage

/* design/pva_voice_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice memory
// One entry per voice, one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
module pva_voice_store import pva_pkg::*; #(
   parameter int  VOICE_COUNT = DEFAULT_VOICE_COUNT,
   localparam int IDX_W       = $clog2(VOICE_COUNT)
) (
   input  logic             clock,
   input  logic [IDX_W-1:0] rd_addr,
   output voice_word_type   rd_data,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  voice_word_type   wr_data
);

   voice_word_type mem [VOICE_COUNT];
   voice_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/polyphonic_voice_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyphonic voice allocator
// Maps note events onto voices, stealing the oldest voice when all are busy.
// A note-on first searches the voices for one to use, then updates every voice
// and reports its start, after a stop if one is reported; other commands update
// every voice and report. One beat is taken at a time: no new beat is taken
// until the last one is done. The pace is set by the single read port of the voice
// memory, visited one voice per cycle while the result output does not stall.
// Reset clears all voices to idle at once and the mode to loop; no sweep.
// ----------------------------------------------------------------------------
module polyphonic_voice_allocator import pva_pkg::*; #(
   parameter int VOICE_COUNT = DEFAULT_VOICE_COUNT
) (
   input  logic              clock,
   input  logic              reset,
   // Configuration
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_voice_mode,
   // Requests
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_cmd,
   input  logic [6:0]        req_key,
   input  logic [6:0]        req_velocity,
   input  logic              req_force_stop,
   input  logic [2:0]        req_voice_sel,
   // Results
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_voice,
   output logic [2:0]        rsp_action,
   output logic              rsp_looping,
   output logic [6:0]        rsp_out_key,
   output logic [6:0]        rsp_out_velocity,
   output logic signed [3:0] rsp_highest_active,
   output logic              rsp_last
);

   localparam int IDX_W = $clog2(VOICE_COUNT);
   localparam int SEL_W = (IDX_W > 3) ? IDX_W : 3;
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(VOICE_COUNT - 1);
   localparam logic signed [7:0] START_AGE = 8'(VOICE_COUNT);
   localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_RESULTS);
   localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(MAX_RESULTS - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_PICK,
      S_UPDATE,
      S_FINAL
   } state_type;

   function automatic logic [3:0] top_voice(input logic [VOICE_COUNT-1:0] play);
      logic [3:0] top;
      top = 4'hF;
      for (int v = 0; v < VOICE_COUNT; v++) begin
         if (play[v]) begin
            top = 4'(v);
         end
      end
      return top;
   endfunction

   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [IDX_W-1:0]        pick_ff, pick_in;
   logic signed [7:0]       pick_age_ff, pick_age_in;
   logic                    match_ff, match_in;
   logic [VOICE_COUNT-1:0]  playing_ff, playing_in;
   logic [1:0]              mode_ff, mode_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    pend_valid_ff, pend_valid_in;
   result_type              pend_ff, pend_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   result_type              rsp_ff, rsp_in;
   logic                    rsp_last_ff, rsp_last_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [6:0]              key_ff, key_in;
   logic [6:0]              vel_ff, vel_in;
   logic                    force_ff, force_in;
   logic [2:0]              sel_ff, sel_in;

   voice_word_type          cur;
   voice_word_type          wr_data;
   logic                    wr_en;
   logic                    cur_play;
   logic                    key_hit;
   logic                    ev;
   logic                    stop_now;
   logic                    write;
   logic                    adv;
   logic                    push;
   logic                    push_last;
   logic                    push_ok;
   logic [VOICE_COUNT-1:0]  play_next;
   logic [VOICE_COUNT-1:0]  play_start;
   result_type              ev_res;
   result_type              push_res;
   result_type              start_res;
   result_type              none_res;

   pva_voice_store #(
      .VOICE_COUNT(VOICE_COUNT)
   ) u_store (
      .clock   (clock),
      .rd_addr (idx_in),
      .rd_data (cur),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (wr_data)
   );

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      pick_in       = pick_ff;
      pick_age_in   = pick_age_ff;
      match_in      = match_ff;
      playing_in    = playing_ff;
      mode_in       = mode_ff;
      cnt_in        = cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      rsp_last_in   = rsp_last_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      vel_in        = vel_ff;
      force_in      = force_ff;
      sel_in        = sel_ff;

      wr_en     = 1'b0;
      wr_data   = cur;
      ev        = 1'b0;
      stop_now  = 1'b0;
      write     = 1'b0;
      adv       = 1'b0;
      push      = 1'b0;
      push_last = 1'b0;
      push_res  = pend_ff;
      play_next = playing_ff;

      cur_play = playing_ff[idx_ff];
      key_hit  = cur_play && (cur.key == key_ff);
      push_ok  = (cnt_ff >= CNT_MAX) || !rsp_valid_ff || rsp_ready;

      ev_res          = '0;
      ev_res.voice    = 3'(idx_ff);
      ev_res.action   = ACT_STOP;
      ev_res.key      = cur_play ? cur.key : 7'd0;

      play_start          = playing_ff;
      play_start[pick_ff] = 1'b1;

      start_res          = '0;
      start_res.voice    = 3'(pick_ff);
      start_res.action   = ACT_START;
      start_res.looping  = (mode_ff != MODE_ONESHOT);
      start_res.key      = key_ff;
      start_res.velocity = vel_ff;
      start_res.highest  = top_voice(play_start);

      none_res         = '0;
      none_res.action  = ACT_NONE;
      none_res.highest = top_voice(playing_ff);

      if (csr_valid && csr_voice_mode <= MODE_ONESHOT) begin
         mode_in = csr_voice_mode;
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            if (req_valid) begin
               cmd_in        = cmd_type'(req_cmd);
               key_in        = req_key;
               vel_in        = req_velocity;
               force_in      = req_force_stop;
               sel_in        = req_voice_sel;
               cnt_in        = '0;
               pend_valid_in = 1'b0;
               match_in      = 1'b0;
               pick_in       = '0;
               state_in      = (cmd_type'(req_cmd) == CMD_NOTE_ON) ? S_PICK : S_UPDATE;
            end
         end

         S_PICK: begin
            // The first idle voice, or one already on this key outside release mode, ends the search.
            if (!cur_play || (key_hit && mode_ff != MODE_RELEASE)) begin
               pick_in  = idx_ff;
               match_in = cur_play;
               idx_in   = '0;
               state_in = S_UPDATE;
            end else begin
               if (idx_ff == '0 || pick_age_ff > cur.age) begin
                  pick_in     = idx_ff;
                  pick_age_in = cur.age;
               end
               if (idx_ff == LAST_IDX) begin
                  idx_in   = '0;
                  state_in = S_UPDATE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end

         S_UPDATE: begin
            case (cmd_ff)
               CMD_NOTE_ON: begin
                  if (match_ff && key_hit) begin
                     ev       = 1'b1;
                     stop_now = 1'b1;
                  end
                  if (idx_ff == pick_ff) begin
                     write           = 1'b1;
                     wr_data.loop_on = (mode_ff != MODE_ONESHOT);
                     wr_data.key     = key_ff;
                     wr_data.age     = START_AGE;
                  end else if (cur_play && !stop_now && cur.age != AGE_FLOOR) begin
                     write       = 1'b1;
                     wr_data.age = cur.age - 8'sd1;
                  end
               end
               CMD_NOTE_OFF: begin
                  if (key_hit) begin
                     ev = 1'b1;
                     if (force_ff) begin
                        stop_now = 1'b1;
                     end else if (mode_ff != MODE_RELEASE) begin
                        ev_res.action   = ACT_END_LOOP;
                        write           = 1'b1;
                        wr_data.loop_on = 1'b0;
                     end else begin
                        ev_res.action  = ACT_RELEASE;
                        ev_res.looping = cur.loop_on;
                     end
                  end
               end
               CMD_STOP: begin
                  if (SEL_W'(idx_ff) == SEL_W'(sel_ff)) begin
                     ev       = 1'b1;
                     stop_now = 1'b1;
                  end
               end
               CMD_MUTE: begin
                  if (cur_play) begin
                     ev       = 1'b1;
                     stop_now = 1'b1;
                  end
               end
               default: begin
                  ev = 1'b0;
               end
            endcase

            if (stop_now) begin
               play_next[idx_ff] = 1'b0;
            end
            ev_res.highest = top_voice(play_next);

            // A new result sends the staged one onward; wait if the output is full.
            adv = !(ev && pend_valid_ff && !push_ok);
            if (adv) begin
               if (ev) begin
                  push          = pend_valid_ff;
                  pend_in       = ev_res;
                  pend_valid_in = 1'b1;
               end
               playing_in = play_next;
               wr_en      = write;
               if (idx_ff == LAST_IDX) begin
                  idx_in   = '0;
                  state_in = S_FINAL;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end

         S_FINAL: begin
            idx_in = '0;
            if (push_ok) begin
               push = 1'b1;
               if (cmd_ff == CMD_NOTE_ON && pend_valid_ff) begin
                  pend_valid_in = 1'b0;
               end else begin
                  push_last     = 1'b1;
                  pend_valid_in = 1'b0;
                  state_in      = S_IDLE;
                  if (cmd_ff == CMD_NOTE_ON) begin
                     push_res            = start_res;
                     playing_in[pick_ff] = 1'b1;
                  end else if (!pend_valid_ff) begin
                     push_res = none_res;
                  end
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Results past the limit are dropped; the one at the limit closes the beat.
      if (push && cnt_ff < CNT_MAX) begin
         rsp_valid_in = 1'b1;
         rsp_in       = push_res;
         rsp_last_in  = push_last || (cnt_ff == CNT_LAST);
         cnt_in       = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         idx_ff        <= '0;
         playing_ff    <= '0;
         mode_ff       <= '0;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         match_ff      <= 1'b0;
         pick_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         playing_ff    <= playing_in;
         mode_ff       <= mode_in;
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         match_ff      <= match_in;
         pick_ff       <= pick_in;
      end
      pick_age_ff <= pick_age_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      vel_ff      <= vel_in;
      force_ff    <= force_in;
      sel_ff      <= sel_in;
   end

   assign csr_ready          = 1'b1;
   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_voice          = rsp_ff.voice;
   assign rsp_action         = rsp_ff.action;
   assign rsp_looping        = rsp_ff.looping;
   assign rsp_out_key        = rsp_ff.key;
   assign rsp_out_velocity   = rsp_ff.velocity;
   assign rsp_highest_active = rsp_ff.highest;
   assign rsp_last           = rsp_last_ff;

   // The entry being written is never the one read in the same cycle.
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (idx_ff != idx_in))
      else $error("voice memory read and write hit the same entry");

   // No staged result may survive into the next request beat.
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_valid_ff)
      else $error("staged result left over at idle");

   // Closing a beat below the limit puts a final result on the output.
   a_final_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINAL && state_in == S_IDLE && cnt_ff < CNT_MAX)
      |=> (rsp_valid_ff && rsp_last_ff))
      else $error("beat closed without a final result");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_MAX)
      else $error("result count beyond limit");

endmodule
